// ===== src/clwd_pkg.sv =====
// ----------------------------------------------------------------------------
// clwd_pkg
// Shared types and constants for the contact-loss watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package clwd_pkg;

  localparam int unsigned TicksPerSecondDef = 1000;
  localparam int unsigned SubW     = 10;
  localparam int unsigned CountW   = 32;
  localparam int unsigned NodeW    = 16;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd600;
  localparam logic [CountW-1:0]   CountMax     = {CountW{1'b1}};

  // Operation codes.
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpStart   = 2'd1;
  localparam logic [1:0] OpStop    = 2'd2;
  localparam logic [1:0] OpContact = 2'd3;

  // Status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StAlready = 2'd1;
  localparam logic [1:0] StTimeout = 2'd2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEnable  = 2'd1;

  typedef struct packed {
    logic              running;
    logic              latched;
    logic [SubW-1:0]   sub;
    logic [CountW-1:0] seconds;
    logic [CountW-1:0] contacts;
    logic [CountW-1:0] expiries;
    logic [NodeW-1:0]  node;
  } wd_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic       reset_req;
  } wd_flags_t;

endpackage

`default_nettype wire

// ===== src/clwd_step.sv =====
// ----------------------------------------------------------------------------
// clwd_step
// Next-state and status logic for one watchdog operation.
// ----------------------------------------------------------------------------
`default_nettype none

module clwd_step #(
  parameter int unsigned TICKS_PER_SECOND = clwd_pkg::TicksPerSecondDef
) (
  input  wire clwd_pkg::wd_state_t               state_i,
  input  wire logic [1:0]                        op_i,
  input  wire logic [clwd_pkg::NodeW-1:0]        node_i,
  input  wire logic [clwd_pkg::TimeoutW-1:0]     timeout_i,
  input  wire logic                              enable_i,
  output clwd_pkg::wd_state_t                    state_o,
  output clwd_pkg::wd_flags_t                    flags_o
);

  localparam logic [clwd_pkg::SubW-1:0] SubWrap = clwd_pkg::SubW'(TICKS_PER_SECOND);

  function automatic logic [clwd_pkg::CountW-1:0] sat_inc(
    input logic [clwd_pkg::CountW-1:0] v
  );
    return (v == clwd_pkg::CountMax) ? v : v + 1'b1;
  endfunction

  logic [clwd_pkg::SubW-1:0]   sub_inc;
  logic                        sec_roll;
  logic [clwd_pkg::CountW-1:0] sec_tick;
  logic                        expire;

  assign sub_inc  = state_i.sub + 1'b1;
  assign sec_roll = (sub_inc >= SubWrap);
  assign sec_tick = sec_roll ? sat_inc(state_i.seconds) : state_i.seconds;
  assign expire   = state_i.running && enable_i &&
                    (sec_tick >= {{(clwd_pkg::CountW-clwd_pkg::TimeoutW){1'b0}}, timeout_i});

  always_comb begin
    state_o = state_i;
    flags_o = '{status: clwd_pkg::StOk, reset_req: 1'b0};
    case (op_i)
      clwd_pkg::OpTick: begin
        state_o.sub     = sec_roll ? '0 : sub_inc;
        state_o.seconds = sec_tick;
        if (expire) begin
          state_o.expiries = sat_inc(state_i.expiries);
          state_o.sub      = '0;
          state_o.seconds  = '0;
          state_o.latched  = 1'b1;
          flags_o.status   = clwd_pkg::StTimeout;
          flags_o.reset_req = !state_i.latched;
        end
      end
      clwd_pkg::OpStart: begin
        if (state_i.running) begin
          flags_o.status = clwd_pkg::StAlready;
        end else begin
          state_o.running = 1'b1;
          state_o.sub     = '0;
          state_o.seconds = '0;
        end
      end
      clwd_pkg::OpStop: begin
        if (!state_i.running) begin
          flags_o.status = clwd_pkg::StAlready;
        end else begin
          state_o.running = 1'b0;
        end
      end
      default: begin
        // Contact: only counts while the watchdog runs.
        if (state_i.running) begin
          state_o.sub      = '0;
          state_o.seconds  = '0;
          state_o.node     = node_i;
          state_o.contacts = sat_inc(state_i.contacts);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/contact_loss_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// contact_loss_watchdog_core
// Contact-loss watchdog: counts ticks and contacts, reports timeouts.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o | op_i, node_i
//   out      | out_valid_o / out_ready_i | status_code_o, reset_request_o, counters
//   cfg      | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// Every operation passes through the input register, then through the update
// logic into the result register. A new beat is accepted every cycle while
// in_ready_o is high; the rate is set by the single update stage.
// While out_ready_i is low the result register holds and the input register
// fills; in_ready_o drops only when both are occupied.
// Reset clears all watchdog state, empties both stages and loads the register
// defaults (timeout 600 seconds, expiry checking enabled).
//
`default_nettype none

module contact_loss_watchdog_core #(
  parameter int unsigned TICKS_PER_SECOND = clwd_pkg::TicksPerSecondDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input channel.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [clwd_pkg::NodeW-1:0]       node_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            status_code_o,
  output logic                                  reset_request_o,
  output logic [clwd_pkg::CountW-1:0]           seconds_since_contact_o,
  output logic [clwd_pkg::CountW-1:0]           contact_total_o,
  output logic [clwd_pkg::CountW-1:0]           expiry_total_o,
  output logic [clwd_pkg::NodeW-1:0]            last_node_seen_o,
  output logic                                  is_running_o,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [clwd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [clwd_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Input register stage.
  logic                        in_valid_q;
  logic [1:0]                  op_q;
  logic [clwd_pkg::NodeW-1:0]  node_q;

  // Result register stage.
  logic                        out_valid_q;
  clwd_pkg::wd_flags_t         flags_q;

  // Architectural state and configuration.
  clwd_pkg::wd_state_t             state_q, state_d;
  clwd_pkg::wd_flags_t             flags_d;
  logic [clwd_pkg::TimeoutW-1:0]   timeout_q;
  logic                            enable_q;

  logic advance;
  logic cfg_timeout_wr;
  logic cfg_enable_wr;

  // The update stage moves whenever the result register is free or draining.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign cfg_timeout_wr = cfg_we_i && (cfg_index_i == clwd_pkg::RegTimeout) &&
                          (cfg_data_i[clwd_pkg::TimeoutW-1:0] != '0);
  assign cfg_enable_wr  = cfg_we_i && (cfg_index_i == clwd_pkg::RegEnable);

  clwd_step #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_step (
    .state_i   (state_q),
    .op_i      (op_q),
    .node_i    (node_q),
    .timeout_i (timeout_q),
    .enable_i  (enable_q),
    .state_o   (state_d),
    .flags_o   (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      node_q <= node_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        flags_q <= flags_d;
      end
    end
  end

  // Watchdog state. Configuration writes are to arrive only while the block is idle, so
  // they never collide with an operation; the user is bound, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      timeout_q <= clwd_pkg::TimeoutReset;
      enable_q  <= 1'b1;
    end else begin
      if (advance && in_valid_q) begin
        state_q <= state_d;
      end else if (cfg_timeout_wr || (cfg_enable_wr && cfg_data_i[0])) begin
        // Writing a timeout, or arming the check, restarts the countdown.
        state_q.sub     <= '0;
        state_q.seconds <= '0;
      end
      if (cfg_timeout_wr) begin
        timeout_q <= cfg_data_i[clwd_pkg::TimeoutW-1:0];
      end
      if (cfg_enable_wr) begin
        enable_q <= cfg_data_i[0];
      end
    end
  end

  // The result fields show the state left by the last delivered operation.
  assign out_valid_o             = out_valid_q;
  assign status_code_o           = flags_q.status;
  assign reset_request_o         = flags_q.reset_req;
  assign seconds_since_contact_o = state_q.seconds;
  assign contact_total_o         = state_q.contacts;
  assign expiry_total_o          = state_q.expiries;
  assign last_node_seen_o        = state_q.node;
  assign is_running_o            = state_q.running;

endmodule

`default_nettype wire

// ===== src/clwd_checker.sv =====
// ----------------------------------------------------------------------------
// clwd_checker
// Port-level assertions for the contact-loss watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clwd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [1:0]                    status_code_o,
  input wire logic                          reset_request_o,
  input wire logic [clwd_pkg::CountW-1:0]   seconds_since_contact_o,
  input wire logic [clwd_pkg::CountW-1:0]   expiry_total_o,
  input wire logic                          is_running_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_code_o) && $stable(expiry_total_o))
    else $error("result beat changed while stalled");

  // A reset request comes only with the very first timeout.
  a_req_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_request_o |->
      status_code_o == clwd_pkg::StTimeout && expiry_total_o == 32'd1)
    else $error("reset request outside the first expiry");

  // A timeout restarts the countdown and only happens while running.
  a_timeout_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_code_o == clwd_pkg::StTimeout |->
      seconds_since_contact_o == '0 && is_running_o && expiry_total_o != '0)
    else $error("timeout beat with inconsistent counters");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      status_code_o == clwd_pkg::StOk || status_code_o == clwd_pkg::StAlready ||
      status_code_o == clwd_pkg::StTimeout)
    else $error("undefined status code");

endmodule

bind contact_loss_watchdog_core clwd_checker u_clwd_checker (.*);

`default_nettype wire

// ===== sim/tb_contact_loss_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// tb_contact_loss_watchdog_core
// Self-checking bench for the contact-loss watchdog core.
// A short directed sequence covers every operation and the run-state corner
// cases. It is followed by several register settings, each with a short stream
// of randomized operations, and then by one full second of ticks on the
// shortest timeout, which produces the first expiry and its reset request.
// A scoreboard class predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------

module tb_contact_loss_watchdog_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned IdlePercent   = 22;
  localparam int unsigned ItemsPerPhase = 20;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned DrainCycles   = 8;
  localparam longint unsigned LimitNs   = 64'd1_000_000;

  // Register indexes that map to nothing in the block.
  localparam logic [clwd_pkg::CfgIdxW-1:0] RegUnusedLo = 2'd2;
  localparam logic [clwd_pkg::CfgIdxW-1:0] RegUnusedHi = 2'd3;

  typedef logic [clwd_pkg::CountW-1:0] count_t;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [1:0]                  status;
    logic                        reset_req;
    logic [clwd_pkg::CountW-1:0] seconds;
    logic [clwd_pkg::CountW-1:0] contacts;
    logic [clwd_pkg::CountW-1:0] expiries;
    logic [clwd_pkg::NodeW-1:0]  node;
    logic                        running;
  } wd_result_t;

  // Watchdog predictor plus the queue of result beats still owed by the block.
  class watchdog_scoreboard;
    logic [clwd_pkg::TimeoutW-1:0] timeout_reg;
    logic                          enable_reg;
    clwd_pkg::wd_state_t           st;
    wd_result_t                    owed_q[$];
    int unsigned                   beat_no;
    int unsigned                   result_no;
    int unsigned                   error_count;

    function new();
      timeout_reg = clwd_pkg::TimeoutReset;
      enable_reg  = 1'b1;
      st          = '0;
      beat_no     = 0;
      result_no   = 0;
      error_count = 0;
    endfunction

    function int unsigned pending_count();
      return owed_q.size();
    endfunction

    function count_t sat_inc(count_t v);
      return (v == clwd_pkg::CountMax) ? v : v + 1'b1;
    endfunction

    function void zero_elapsed();
      st.sub     = '0;
      st.seconds = '0;
    endfunction

    // A zero timeout is dropped; enable keeps only bit 0 of the data.
    function void write_register(logic [clwd_pkg::CfgIdxW-1:0] idx,
                                 logic [clwd_pkg::CfgDataW-1:0] data);
      case (idx)
        clwd_pkg::RegTimeout: begin
          if (data[clwd_pkg::TimeoutW-1:0] != '0) begin
            timeout_reg = data[clwd_pkg::TimeoutW-1:0];
            zero_elapsed();
          end
        end
        clwd_pkg::RegEnable: begin
          enable_reg = data[0];
          if (data[0]) begin
            zero_elapsed();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [clwd_pkg::NodeW-1:0] node);
      wd_result_t r;
      r        = '0;
      r.status = clwd_pkg::StOk;
      case (op)
        clwd_pkg::OpTick: begin
          // Counters advance whether or not the watchdog is armed.
          st.sub = st.sub + 1'b1;
          if (st.sub >= clwd_pkg::TicksPerSecondDef) begin
            st.sub     = '0;
            st.seconds = sat_inc(st.seconds);
          end
          if (st.running && enable_reg && st.seconds >= timeout_reg) begin
            st.expiries = sat_inc(st.expiries);
            zero_elapsed();
            r.status = clwd_pkg::StTimeout;
            if (!st.latched) begin
              st.latched  = 1'b1;
              r.reset_req = 1'b1;
            end
          end
        end
        clwd_pkg::OpStart: begin
          if (st.running) begin
            r.status = clwd_pkg::StAlready;
          end else begin
            st.running = 1'b1;
            zero_elapsed();
          end
        end
        clwd_pkg::OpStop: begin
          if (!st.running) begin
            r.status = clwd_pkg::StAlready;
          end else begin
            st.running = 1'b0;
          end
        end
        default: begin
          // Contacts only count while the watchdog runs.
          if (st.running) begin
            zero_elapsed();
            st.node     = node;
            st.contacts = sat_inc(st.contacts);
          end
        end
      endcase
      r.seconds  = st.seconds;
      r.contacts = st.contacts;
      r.expiries = st.expiries;
      r.node     = st.node;
      r.running  = st.running;
      owed_q.push_back(r);
      beat_no++;
    endfunction

    task report_mismatch(string what, count_t got, count_t want);
      $display("%0t ns: result %0d %s: got %0h, expected %0h",
               $time, result_no, what, got, want);
      error_count++;
    endtask

    task check_result(wd_result_t got);
      wd_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("arrived with nothing pending", got.seconds, '0);
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status_code", count_t'(got.status), count_t'(want.status));
        if (got.reset_req !== want.reset_req)
          report_mismatch("reset_request", count_t'(got.reset_req),
                          count_t'(want.reset_req));
        if (got.seconds !== want.seconds)
          report_mismatch("seconds_since_contact", got.seconds, want.seconds);
        if (got.contacts !== want.contacts)
          report_mismatch("contact_total", got.contacts, want.contacts);
        if (got.expiries !== want.expiries)
          report_mismatch("expiry_total", got.expiries, want.expiries);
        if (got.node !== want.node)
          report_mismatch("last_node_seen", count_t'(got.node), count_t'(want.node));
        if (got.running !== want.running)
          report_mismatch("is_running", count_t'(got.running), count_t'(want.running));
      end
      result_no++;
    endtask
  endclass

  // Every input starts at a known value.
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic [1:0]                    op_i        = clwd_pkg::OpTick;
  logic [clwd_pkg::NodeW-1:0]    node_i      = '0;
  logic                          out_ready_i = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [clwd_pkg::CfgIdxW-1:0]  cfg_index_i = clwd_pkg::RegTimeout;
  logic [clwd_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [1:0]                    status_code_o;
  logic                          reset_request_o;
  logic [clwd_pkg::CountW-1:0]   seconds_since_contact_o;
  logic [clwd_pkg::CountW-1:0]   contact_total_o;
  logic [clwd_pkg::CountW-1:0]   expiry_total_o;
  logic [clwd_pkg::NodeW-1:0]    last_node_seen_o;
  logic                          is_running_o;

  // While set, neither side idles; used for one whole phase.
  bit steady_flow = 1'b0;

  wd_result_t seen;

  watchdog_scoreboard sb = new();

  contact_loss_watchdog_core uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .op_i                    (op_i),
    .node_i                  (node_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .status_code_o           (status_code_o),
    .reset_request_o         (reset_request_o),
    .seconds_since_contact_o (seconds_since_contact_o),
    .contact_total_o         (contact_total_o),
    .expiry_total_o          (expiry_total_o),
    .last_node_seen_o        (last_node_seen_o),
    .is_running_o            (is_running_o),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // The receiver stalls at random, except during the steady phase.
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Result monitor. Outputs are sampled at the rising edge, before the
  // block's registers take their new values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.status    = status_code_o;
      seen.reset_req = reset_request_o;
      seen.seconds   = seconds_since_contact_o;
      seen.contacts  = contact_total_o;
      seen.expiries  = expiry_total_o;
      seen.node      = last_node_seen_o;
      seen.running   = is_running_o;
      sb.check_result(seen);
    end
  end

  // Called at a falling edge. Possibly idles a few cycles, then presents the
  // beat and holds it until the block takes it. Returns at a falling edge.
  task automatic send_item(input logic [1:0] op, input logic [clwd_pkg::NodeW-1:0] node);
    while (!steady_flow && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    node_i     <= node;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, node);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every owed result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write; the port has no handshake, so the write needs no wait.
  task automatic write_reg(input logic [clwd_pkg::CfgIdxW-1:0] idx,
                           input logic [clwd_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Register settings per phase. Phase 0 runs on the reset defaults.
  task automatic configure_phase(input int unsigned phase);
    case (phase)
      1: begin
        // Shortest timeout.
        write_reg(clwd_pkg::RegTimeout, 16'd1);
        write_reg(clwd_pkg::RegEnable, 16'd1);
      end
      2: begin
        // A zero timeout must be dropped, and unused indexes do nothing.
        write_reg(clwd_pkg::RegTimeout, 16'd0);
        write_reg(RegUnusedLo, 16'hFFFF);
        write_reg(RegUnusedHi, 16'($urandom));
        steady_flow <= 1'b1;
      end
      3: begin
        // Only bit 0 matters: this disarms expiry checking.
        write_reg(clwd_pkg::RegEnable, 16'hFFFE);
        steady_flow <= 1'b0;
      end
      4: begin
        write_reg(clwd_pkg::RegEnable, 16'h0001);
        write_reg(clwd_pkg::RegTimeout, 16'd2);
      end
      5: begin
        write_reg(clwd_pkg::RegTimeout, 16'hFFFF);
      end
      6: begin
        write_reg(clwd_pkg::RegTimeout, 16'($urandom_range(1, 3)));
        write_reg(clwd_pkg::RegEnable, 16'($urandom) | 16'h0001);
      end
      default: begin
        write_reg(clwd_pkg::RegTimeout, 16'($urandom));
        write_reg(clwd_pkg::RegEnable, 16'($urandom));
      end
    endcase
  endtask

  // Starting from the reset state: stopped, timeout 600, armed.
  task automatic run_directed();
    send_item(clwd_pkg::OpContact, 16'hFFFF);   // contact while stopped is ignored
    send_item(clwd_pkg::OpStop, 16'h0000);      // redundant stop
    send_item(clwd_pkg::OpTick, 16'hFFFF);
    send_item(clwd_pkg::OpStart, 16'h0000);
    send_item(clwd_pkg::OpStart, 16'hFFFF);     // redundant start
    send_item(clwd_pkg::OpContact, 16'h0000);
    send_item(clwd_pkg::OpContact, 16'hFFFF);
    send_item(clwd_pkg::OpTick, 16'h0000);
    send_item(clwd_pkg::OpTick, 16'h0000);
    send_item(clwd_pkg::OpContact, 16'hA5A5);
    send_item(clwd_pkg::OpTick, 16'h5A5A);
    send_item(clwd_pkg::OpStop, 16'hFFFF);
    send_item(clwd_pkg::OpContact, 16'h1234);   // ignored again, last node stays
    send_item(clwd_pkg::OpTick, 16'h0000);
    send_item(clwd_pkg::OpStop, 16'h0000);
    send_item(clwd_pkg::OpStart, 16'h0000);
    send_item(clwd_pkg::OpContact, 16'h5A5A);
    send_item(clwd_pkg::OpTick, 16'hFFFF);
  endtask

  // Mostly well-formed traffic: short tick bursts mixed with contacts, starts
  // and stops. A little raw noise and an occasional full drain of the pipeline
  // are thrown in. Runs until about item_count beats have been sent.
  task automatic run_random_ops(input int unsigned item_count);
    int unsigned pick;
    int unsigned burst;
    int unsigned stop_at;
    stop_at = sb.beat_no + item_count;
    while (sb.beat_no < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_item(clwd_pkg::OpTick, 16'($urandom));
      end else if (pick < 73) begin
        send_item(clwd_pkg::OpContact, 16'($urandom));
      end else if (pick < 85) begin
        send_item(clwd_pkg::OpStart, 16'($urandom));
      end else if (pick < 97) begin
        send_item(clwd_pkg::OpStop, 16'($urandom));
      end else if (pick < 99) begin
        send_item(2'($urandom), 16'($urandom));
      end else begin
        wait_all_results();
      end
    end
  endtask

  // One second of ticks on the shortest timeout: the last tick crosses the
  // second boundary and brings the first expiry with its reset request.
  task automatic run_expiry();
    wait_all_results();
    write_reg(clwd_pkg::RegTimeout, 16'd1);
    write_reg(clwd_pkg::RegEnable, 16'd1);
    send_item(clwd_pkg::OpStart, 16'($urandom));
    repeat (clwd_pkg::TicksPerSecondDef) send_item(clwd_pkg::OpTick, 16'($urandom));
    send_item(clwd_pkg::OpTick, 16'($urandom));
    send_item(clwd_pkg::OpContact, 16'($urandom));
    send_item(clwd_pkg::OpTick, 16'($urandom));
    send_item(clwd_pkg::OpStop, 16'($urandom));
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      // Registers change only with the pipeline empty.
      if (phase != 0) begin
        wait_all_results();
        configure_phase(phase);
      end
      run_random_ops(ItemsPerPhase);
    end
    run_expiry();

    wait_all_results();
    // A few more cycles so that a stray extra beat would still be seen.
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("contact_loss_watchdog_core: match");
    end else begin
      $display("contact_loss_watchdog_core: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legitimate run.
  initial begin
    #(LimitNs);
    $display("contact_loss_watchdog_core: mismatch");
    $finish;
  end

endmodule
